// File: hdl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, register indexes and the built-in tone table of the beep
// pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int HzW     = 16;
    localparam int MsW     = 9;
    localparam int StepW   = 3;
    localparam int EventW  = 3;
    localparam int MaskW   = 8;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 8;

    localparam logic [MsW-1:0] ElapsedMax = 9'd511;

    // item kinds carried on the input tuser
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_TRIGGER = 1'b1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_MASTER_ENABLE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_EVENT_MASK    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_DIFF_DRIVE    = 2'd2;

    typedef struct packed {
        logic             master_enable;
        logic [MaskW-1:0] event_enable_mask;
        logic             differential_drive;
    } bps_cfg_t;

    typedef struct packed {
        logic           done_pulse;
        logic           invert_on;
        logic           busy_res;
        logic [HzW-1:0] tone_hz;
    } bps_result_t;

    // index of the final step of each pattern
    function automatic logic [StepW-1:0] pat_last(input logic [EventW-1:0] pat);
        logic [StepW-1:0] r;
        case (pat)
            3'd1:    r = 3'd2;
            3'd2:    r = 3'd1;
            3'd3:    r = 3'd2;
            3'd5:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [HzW-1:0] step_hz(input logic [EventW-1:0] pat,
                                                input logic [StepW-1:0]  stp);
        logic [HzW-1:0] r;
        case ({pat, stp})
            6'o00:   r = 16'd4200;
            6'o10:   r = 16'd4200;
            6'o12:   r = 16'd4200;
            6'o20:   r = 16'd3600;
            6'o21:   r = 16'd4200;
            6'o30:   r = 16'd4200;
            6'o32:   r = 16'd4200;
            6'o40:   r = 16'd3200;
            6'o50:   r = 16'd4200;
            6'o52:   r = 16'd3600;
            6'o54:   r = 16'd3000;
            6'o60:   r = 16'd4200;
            6'o70:   r = 16'd4200;
            default: r = '0;  // silent gaps and unused slots
        endcase
        return r;
    endfunction

    function automatic logic [MsW-1:0] step_ms(input logic [EventW-1:0] pat,
                                               input logic [StepW-1:0]  stp);
        logic [MsW-1:0] r;
        case ({pat, stp})
            6'o00:   r = 9'd220;
            6'o10:   r = 9'd110;
            6'o11:   r = 9'd90;
            6'o12:   r = 9'd110;
            6'o20:   r = 9'd70;
            6'o21:   r = 9'd110;
            6'o30:   r = 9'd50;
            6'o31:   r = 9'd45;
            6'o32:   r = 9'd50;
            6'o40:   r = 9'd260;
            6'o50:   r = 9'd150;
            6'o51:   r = 9'd140;
            6'o52:   r = 9'd150;
            6'o53:   r = 9'd140;
            6'o54:   r = 9'd200;
            6'o60:   r = 9'd80;
            6'o70:   r = 9'd60;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/bps_core.sv
// ----------------------------------------------------------------------------
// bps_core
// Sequencer state (pattern, step, step timer) and the next-state logic that
// applies one tick or trigger and forms the result word for it.
// ----------------------------------------------------------------------------
module bps_core
    import bps_pkg::*;
#(
    parameter int NUM_EVENTS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              func,
    input  logic [EventW-1:0] event_id,
    input  bps_cfg_t          cfg,
    output bps_result_t       res
);

    logic              active_reg,  active_next;
    logic [EventW-1:0] pattern_reg, pattern_next;
    logic [StepW-1:0]  step_reg,    step_next;
    logic [MsW-1:0]    elapsed_reg, elapsed_next;

    logic              trig_ok;
    logic              done;
    logic [MsW-1:0]    elapsed_inc;
    logic [MsW-1:0]    dur;

    assign trig_ok = ({1'b0, event_id} < 4'(NUM_EVENTS)) && cfg.master_enable
                     && cfg.event_enable_mask[event_id];
    assign dur         = step_ms(pattern_reg, step_reg);
    assign elapsed_inc = (elapsed_reg < ElapsedMax) ? elapsed_reg + 9'd1 : elapsed_reg;

    always_comb
    begin
        active_next  = active_reg;
        pattern_next = pattern_reg;
        step_next    = step_reg;
        elapsed_next = elapsed_reg;
        done         = 1'b0;
        if (func == FUNC_TRIGGER)
        begin
            if (trig_ok)
            begin
                active_next  = 1'b1;
                pattern_next = event_id;
                step_next    = '0;
                elapsed_next = '0;
            end
        end
        else if (active_reg)
        begin
            if (elapsed_inc >= dur)
            begin
                elapsed_next = '0;
                if (step_reg == pat_last(pattern_reg))
                begin
                    active_next = 1'b0;
                    step_next   = '0;
                    done        = 1'b1;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            else
            begin
                elapsed_next = elapsed_inc;
            end
        end
    end

    assign res.tone_hz    = active_next ? step_hz(pattern_next, step_next) : '0;
    assign res.busy_res   = active_next;
    assign res.invert_on  = active_next & cfg.differential_drive;
    assign res.done_pulse = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            pattern_reg <= '0;
            step_reg    <= '0;
            elapsed_reg <= '0;
        end
        else if (fire)
        begin
            active_reg  <= active_next;
            pattern_reg <= pattern_next;
            step_reg    <= step_next;
            elapsed_reg <= elapsed_next;
        end
    end

    a_done_ends_play: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.done_pulse |=> !active_reg)
        else $error("pattern still active after finishing");

    a_no_done_on_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        fire && func == FUNC_TRIGGER |-> !res.done_pulse)
        else $error("done flagged on a trigger");

    a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> step_reg == '0 && elapsed_reg == '0)
        else $error("step state left over while idle");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> step_reg <= pat_last(pattern_reg))
        else $error("step beyond end of pattern");

endmodule

// File: hdl/beep_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// beep_pattern_sequencer
// Plays built-in beep patterns on trigger events, timed by millisecond ticks.
// ----------------------------------------------------------------------------
// One word is taken per clock when the output side keeps up. Each word passes
// an input register, then the sequencer's next-state logic and a table read,
// then the result register. Both registers hold under backpressure, and a new
// word is taken while a result still waits on the output. Configuration
// writes are registered and should be made while no word is in flight.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer
    import bps_pkg::*;
#(
    parameter int NUM_EVENTS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [2:0] event_id, rest zero
    input  logic               s_tuser,   // [0] func
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // [15:0] tone_hz, [16] busy_res,
                                          // [17] invert_on, [18] done_pulse
    // configuration
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data
);

    logic              in_valid_reg;
    logic              func_reg;
    logic [EventW-1:0] event_reg;
    logic              out_valid_reg;
    bps_result_t       result_reg;
    bps_cfg_t          cfg_reg;
    bps_result_t       res;
    logic              fire;

    // the held word moves on when the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.master_enable      <= 1'b1;
            cfg_reg.event_enable_mask  <= '1;
            cfg_reg.differential_drive <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MASTER_ENABLE: cfg_reg.master_enable      <= cfg_data[0];
                REG_EVENT_MASK:    cfg_reg.event_enable_mask  <= cfg_data[MaskW-1:0];
                REG_DIFF_DRIVE:    cfg_reg.differential_drive <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg  <= s_tuser;
            event_reg <= s_tdata[EventW-1:0];
        end
        if (fire)
            result_reg <= res;
    end

    bps_core #(
        .NUM_EVENTS (NUM_EVENTS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .func     (func_reg),
        .event_id (event_reg),
        .cfg      (cfg_reg),
        .res      (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, result_reg.done_pulse, result_reg.invert_on,
                       result_reg.busy_res, result_reg.tone_hz};

endmodule
